// ----- rtl/dws_pkg.sv -----
// shared types, constants and codes for the searchable deque
`default_nettype none

package dws_pkg;

    // storage geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    // operation codes
    typedef enum logic [2:0] {
        OP_PUSH_END   = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_END    = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load_end;    // cell at position count takes the new value
        logic shift_up;    // every cell takes its front neighbor, cell 0 the new value
        logic shift_down;  // every cell but the last takes its back neighbor
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/dws_cell.sv -----
// one storage cell of the deque chain: holds an entry, shifts, compares
`default_nettype none

module dws_cell
    import dws_pkg::*;
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [IDX_W-1:0] idx,
    input  wire logic [CNT_W-1:0] cnt,
    input  wire logic [VAL_W-1:0] value,
    input  wire logic [VAL_W-1:0] prev_data,
    input  wire logic [VAL_W-1:0] next_data,
    output logic [VAL_W-1:0]      data,
    output logic                  hit,
    output logic [VAL_W-1:0]      tail
);

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic [CNT_W-1:0] pos;
    logic             occupied;
    logic             is_last;

    // position of this cell relative to the fill level
    assign pos      = CNT_W'(idx);
    assign occupied = pos < cnt;
    assign is_last  = (pos + CNT_W'(1)) == cnt;

    // next entry value
    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            data_next = prev_data;
        end
        else if (ctl.shift_down)
        begin
            data_next = next_data;
        end
        else if (ctl.load_end && (pos == cnt))
        begin
            data_next = value;
        end
    end

    // entry storage, no reset: read only once written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // key compare and tail pick
    assign data = data_reg;
    assign hit  = occupied && (data_reg == value);
    assign tail = is_last ? data_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/deque_with_search.sv -----
// top level of the searchable deque: cell chain, fill count and result register
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_ready, op, value                 | into block
//  out     | out_valid, out_ready, status, found,          | out of block
//          | entry_count, removed_value                    |
//
// one transaction per cycle unless stalled: the operation is decoded and every
// cell compares or shifts in the accepting cycle; its result is registered.
// entries always sit at cells 0..count-1 with the front in cell 0.
// reset clears count and result valid, not the entries or the result payload.
// a stalled result holds the input side only while the result register is full.
`default_nettype none

module deque_with_search
    import dws_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [2:0]              op,
    input  wire logic signed [VAL_W-1:0] value,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   status,
    output logic                         found,
    output logic [4:0]                   entry_count,
    output logic signed [VAL_W-1:0]      removed_value
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic             found_reg;
    logic             found_next;
    logic [VAL_W-1:0] removed_reg;
    logic [VAL_W-1:0] removed_next;
    logic             accept;
    logic             full;
    logic             empty;
    cell_ctl_t        ctl;
    cell_ctl_t        ctl_raw;
    logic [VAL_W-1:0] cell_data [DEPTH];
    logic [VAL_W-1:0] cell_tail [DEPTH];
    logic [DEPTH-1:0] cell_hit;
    logic [VAL_W-1:0] tail_value;

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;

    // cell chain
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [VAL_W-1:0] prev_d;
        logic [VAL_W-1:0] next_d;

        if (g == 0)
        begin : g_first
            assign prev_d = value;
        end
        else
        begin : g_mid
            assign prev_d = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[g];
        end
        else
        begin : g_inner
            assign next_d = cell_data[g+1];
        end

        dws_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .idx       (IDX_W'(g)),
            .cnt       (count_reg),
            .value     (value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[g]),
            .hit       (cell_hit[g]),
            .tail      (cell_tail[g])
        );
    end

    // tail value: only the last occupied cell contributes, all others give zero
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    // operation decode
    always_comb
    begin
        ctl_raw      = '0;
        count_next   = count_reg;
        status_next  = ST_OK;
        found_next   = 1'b0;
        removed_next = '0;
        case (op)
            OP_PUSH_END:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl_raw.load_end = 1'b1;
                    count_next       = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl_raw.shift_up = 1'b1;
                    count_next       = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ctl_raw.shift_down = 1'b1;
                    removed_next       = cell_data[0];
                    count_next         = count_reg - CNT_W'(1);
                end
            end
            OP_POP_END:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    removed_next = tail_value;
                    count_next   = count_reg - CNT_W'(1);
                end
            end
            OP_SEARCH:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    found_next = |cell_hit;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // cells only move on an accepted transaction
    assign ctl = accept ? ctl_raw : '0;

    // fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= status_next;
            found_reg   <= found_next;
            removed_reg <= removed_next;
        end
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign entry_count   = 5'(count_reg);
    assign removed_value = removed_reg;

endmodule

`default_nettype wire

// ----- rtl/dws_check.sv -----
// port-level checker for the searchable deque, bound to the top level
`default_nettype none

module dws_check
    import dws_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [1:0]              status,
    input wire logic                    found,
    input wire logic [4:0]              entry_count,
    input wire logic signed [VAL_W-1:0] removed_value
);

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
            && $stable(entry_count) && $stable(removed_value))
        else $error("result changed while stalled");

    // a refused push is only reported at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == 5'(DEPTH))
        else $error("full status below capacity");

    // empty status means nothing is stored, found or removed
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> entry_count == '0 && !found
            && removed_value == '0)
        else $error("empty status with stored entries or payload");

    // count never exceeds the store
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 5'(DEPTH))
        else $error("entry count beyond depth");

    // a hit cannot come with a refused or failed transaction
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_OK && entry_count != '0)
        else $error("found flag on a failed transaction");

endmodule

bind deque_with_search dws_check u_dws_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found         (found),
    .entry_count   (entry_count),
    .removed_value (removed_value)
);

`default_nettype wire

// ----- test/testbench.sv -----
// testbench for the searchable deque: directed and random transactions checked against a queue model
`default_nettype none

module testbench;
    import dws_pkg::*;

    // op codes with no function in the block
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 30;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        status_t                 status;
        logic                    found;
        logic [4:0]              count;
        logic signed [VAL_W-1:0] removed;
    } outcome_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [2:0]              op = OP_PUSH_END;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              status;
    logic                    found;
    logic [4:0]              entry_count;
    logic signed [VAL_W-1:0] removed_value;

    // model of the stored list, front at index 0
    logic signed [VAL_W-1:0] list_entries[$];
    outcome_t                pending_outcomes[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  hold_off_cycles = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;

    deque_with_search u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found         (found),
        .entry_count   (entry_count),
        .removed_value (removed_value)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        if (error_count < PRINT_LIMIT)
            $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp,
                     cycle_count);
        error_count++;
    endtask

    // apply one operation to the list model and return its outcome
    function automatic outcome_t apply_operation(input logic [2:0] code,
                                                 input logic signed [VAL_W-1:0] data);
        outcome_t r;
        r = '{status: ST_OK, found: 1'b0, count: '0, removed: '0};
        case (code)
            OP_PUSH_END, OP_PUSH_FRONT:
            begin
                if (list_entries.size() >= DEPTH)
                    r.status = ST_FULL;
                else if (code == OP_PUSH_END)
                    list_entries.push_back(data);
                else
                    list_entries.push_front(data);
            end
            OP_POP_FRONT, OP_POP_END:
            begin
                if (list_entries.size() == 0)
                    r.status = ST_EMPTY;
                else if (code == OP_POP_FRONT)
                    r.removed = list_entries.pop_front();
                else
                    r.removed = list_entries.pop_back();
            end
            OP_SEARCH:
            begin
                if (list_entries.size() == 0)
                    r.status = ST_EMPTY;
                foreach (list_entries[i])
                    if (list_entries[i] == data)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.count = 5'(list_entries.size());
        return r;
    endfunction

    // predict on every accepted transaction, check every delivered result
    always @(posedge clk)
    begin : scoreboard
        outcome_t exp;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_outcomes.push_back(apply_operation(op, value));
            if (out_valid && out_ready)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("unexpected result", {30'd0, status}, '0);
                else
                begin
                    exp = pending_outcomes.pop_front();
                    if (status !== exp.status)
                        report_mismatch("status", {30'd0, status}, {30'd0, exp.status});
                    if (found !== exp.found)
                        report_mismatch("found", {31'd0, found}, {31'd0, exp.found});
                    if (entry_count !== exp.count)
                        report_mismatch("entry_count", {27'd0, entry_count}, {27'd0, exp.count});
                    if (removed_value !== exp.removed)
                        report_mismatch("removed_value", removed_value, exp.removed);
                end
            end
        end
    end

    // result side: random stalls, or a long hold-off when requested
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else
                out_ready <= !(receiver_idles && $urandom_range(0, 99) < 16);
        end
    end

    // offer one transaction and wait until it is taken
    task automatic send_op(input logic [2:0] code, input logic signed [VAL_W-1:0] data);
        while (sender_idles && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        value    <= data;
        // in_ready only moves at rising edges, so its mid-cycle value decides the next edge
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // empty-list cases, extreme values, spare codes, removal of the last entry
    task automatic test_edge_cases();
        send_op(OP_SEARCH, VAL_MIN);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_END, '0);
        send_op(OP_SPARE_FIRST, VAL_MAX);
        send_op(OP_PUSH_END, VAL_MAX);
        send_op(OP_PUSH_FRONT, VAL_MIN);
        send_op(OP_SEARCH, VAL_MIN);
        send_op(OP_SEARCH, '0);
        send_op(OP_PUSH_END, -32'sd1);
        send_op(OP_PUSH_END, '0);
        for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
            send_op(3'(c), VAL_MIN);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_END, '0);
        send_op(OP_SEARCH, VAL_MAX);
        send_op(OP_POP_END, '0);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_SEARCH, VAL_MAX);
        send_op(OP_POP_END, '0);
        wait_results_drained();
    endtask

    // fill from both ends, refuse pushes when full, drain from both ends
    task automatic test_full_store();
        for (int i = 0; i < DEPTH; i++)
            send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_END, $urandom);
        send_op(OP_PUSH_END, VAL_MAX);
        send_op(OP_PUSH_FRONT, VAL_MIN);
        send_op(OP_SEARCH, list_entries[DEPTH-1]);
        for (int i = 0; i < DEPTH + 1; i++)
            send_op(i[0] ? OP_POP_END : OP_POP_FRONT, '0);
    endtask

    // results blocked for a long time while transactions keep coming
    task automatic test_back_pressure();
        hold_off_cycles = 60;
        for (int i = 0; i < 30; i++)
            send_op(($urandom_range(0, 3) != 0) ? OP_PUSH_END : OP_SEARCH, $urandom);
        wait_results_drained();
        for (int i = 0; i < 30; i++)
            send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_END, '0);
    endtask

    // random transactions in bursts that lean toward filling or draining
    task automatic test_random(input int count);
        int                      lean;
        int                      pick;
        logic [2:0]              code;
        logic signed [VAL_W-1:0] data;
        lean = 2;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                lean = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                code = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            else if (pick < 18)
                code = OP_SEARCH;
            else if ($urandom_range(0, 99) < (lean == 0 ? 75 : (lean == 1 ? 25 : 50)))
                code = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_END;
            else
                code = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_END;
            case ($urandom_range(0, 9))
                0:       data = VAL_MIN;
                1:       data = VAL_MAX;
                default: data = $urandom;
            endcase
            if (code == OP_SEARCH && list_entries.size() != 0 && $urandom_range(0, 1))
                data = list_entries[$urandom_range(0, list_entries.size() - 1)];
            send_op(code, data);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_cases();
        test_full_store();
        test_back_pressure();
        test_random(400);
        // a stretch with no idling on either side
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random(250);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        test_random(330);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
